/* src/kdc_pkg.sv */
`timescale 1ns / 1ps
package kdc_pkg;

    localparam int KEY_IDX_W    = 3;
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int TALLY_W      = 2;
    localparam int NUM_KEYS_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD    = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST      = 16'd50;
    localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RST = 16'd400;
    localparam logic [CFG_W-1:0] LONG_HOLD_RST     = 16'd1000;

    localparam logic [TALLY_W-1:0] TALLY_MAX          = 2'd3;
    localparam logic [TALLY_W-1:0] DOUBLE_MIN_PRESSES = 2'd2;

    typedef struct packed {
        logic              raw_prev;
        logic              debounced_level;
        logic [TIME_W-1:0] change_stamp;
        logic [TIME_W-1:0] press_stamp;
        logic [TIME_W-1:0] release_stamp;
        logic [TALLY_W-1:0] press_tally;
        logic              press_consumed;
        logic              click_pending;
    } t_key_state;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] double_window_ms;
        logic [CFG_W-1:0] long_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic single_click;
        logic double_click;
        logic long_hold;
        logic stable_level;
    } t_flags;

endpackage

/* src/kdc_eval.sv */
`timescale 1ns / 1ps
module kdc_eval (
    input  kdc_pkg::t_key_state          i_state,
    input  logic                         i_raw,
    input  logic [kdc_pkg::TIME_W-1:0]   i_now,
    input  kdc_pkg::t_cfg                i_cfg,
    output kdc_pkg::t_key_state          o_state,
    output kdc_pkg::t_flags              o_flags
);
    import kdc_pkg::*;

    logic [TIME_W-1:0] chg_stamp;
    logic [TIME_W-1:0] debounce_ext;
    logic [TIME_W-1:0] window_ext;
    logic [TIME_W-1:0] hold_ext;
    logic              settled;
    logic              flip;
    logic              press_edge;
    logic              release_edge;
    t_key_state        s1;
    t_key_state        s2;
    t_key_state        s3;
    logic              dbl_hit;
    logic              dbl_gap_ok;
    logic              dbl_stale;
    logic              lng_hit;
    logic [TIME_W-1:0] held_for;

    assign debounce_ext = TIME_W'(i_cfg.debounce_ms);
    assign window_ext   = TIME_W'(i_cfg.double_window_ms);
    assign hold_ext     = TIME_W'(i_cfg.long_hold_ms);

    // debounce
    assign chg_stamp    = (i_raw != i_state.raw_prev) ? i_now : i_state.change_stamp;
    assign settled      = (i_now - chg_stamp) > debounce_ext;
    assign flip         = settled && (i_raw != i_state.debounced_level);
    assign press_edge   = flip && i_raw;
    assign release_edge = flip && !i_raw;

    always_comb begin
        s1                 = i_state;
        s1.raw_prev        = i_raw;
        s1.change_stamp    = chg_stamp;
        s1.debounced_level = flip ? i_raw : i_state.debounced_level;
        if (press_edge) begin
            s1.press_stamp    = i_now;
            s1.press_consumed = 1'b0;
            if (i_state.press_tally != TALLY_MAX) begin
                s1.press_tally = i_state.press_tally + TALLY_W'(1);
            end
        end
        if (release_edge) begin
            s1.release_stamp = i_now;
            if (!i_state.press_consumed) begin
                s1.click_pending = 1'b1;
            end
        end
    end

    // single click
    always_comb begin
        s2 = s1;
        if (s1.click_pending) begin
            s2.click_pending  = 1'b0;
            s2.press_consumed = 1'b1;
        end
    end

    // double click
    assign held_for   = i_now - s2.press_stamp;
    assign dbl_gap_ok = (s2.press_stamp - s2.release_stamp) <= window_ext;
    assign dbl_stale  = held_for > window_ext;
    assign dbl_hit    = (s2.press_tally >= DOUBLE_MIN_PRESSES) && dbl_gap_ok;

    always_comb begin
        s3 = s2;
        if (s2.press_tally >= DOUBLE_MIN_PRESSES) begin
            if (dbl_gap_ok) begin
                s3.press_tally    = '0;
                s3.press_consumed = 1'b1;
                s3.click_pending  = 1'b0;
            end else if (dbl_stale) begin
                s3.press_tally = '0;
            end
        end
    end

    // long press
    assign lng_hit = s3.debounced_level && !s3.press_consumed && (held_for >= hold_ext);

    always_comb begin
        o_state = s3;
        if (lng_hit) begin
            o_state.press_consumed = 1'b1;
            o_state.click_pending  = 1'b0;
        end
    end

    assign o_flags.single_click = s1.click_pending;
    assign o_flags.double_click = dbl_hit;
    assign o_flags.long_hold    = lng_hit;
    assign o_flags.stable_level = s3.debounced_level;

endmodule

/* src/key_debounce_click_classifier.sv */
`timescale 1ns / 1ps
// Debounce and click classifier for up to NUM_KEYS keys. Each request is one
// sample of one key (index, raw level, millisecond time stamp) and yields one
// result: single, double and long press flags plus the debounced level. One
// sample is taken every clock cycle unless the result side stalls; a result
// passes through the input register, then the result register, and the key's
// state is read and rewritten as the sample moves between the two, so
// samples of the same key may follow each other back to back. A sample whose
// index is NUM_KEYS or above leaves all state alone and returns all-zero flags.
// Register writes through the configuration port take effect at once.
module key_debounce_click_classifier #(
    parameter int NUM_KEYS = kdc_pkg::NUM_KEYS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kdc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [kdc_pkg::KEY_IDX_W-1:0] i_key_index,
    input  logic                          i_raw_pressed,
    input  logic [kdc_pkg::TIME_W-1:0]    i_now_ms,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_single_click,
    output logic                          o_double_click,
    output logic                          o_long_hold,
    output logic                          o_stable_level
);
    import kdc_pkg::*;

    localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    t_cfg                   r_cfg;
    t_key_state             r_keys [NUM_KEYS];
    logic                   r_in_valid;
    logic                   r_in_range;
    logic [KEY_AW-1:0]      r_key;
    logic                   r_raw;
    logic [TIME_W-1:0]      r_now;
    logic                   r_out_valid;
    t_flags                 r_out;

    logic [KEY_AW-1:0]      key_sel;
    logic                   advance;
    t_key_state             cur_state;
    t_key_state             n_state;
    t_flags                 n_flags;

    assign advance = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || advance;
    assign key_sel = r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms      <= DEBOUNCE_RST;
            r_cfg.double_window_ms <= DOUBLE_WINDOW_RST;
            r_cfg.long_hold_ms     <= LONG_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE:      r_cfg.debounce_ms      <= i_cfg_data;
                CFG_DOUBLE_WINDOW: r_cfg.double_window_ms <= i_cfg_data;
                CFG_LONG_HOLD:     r_cfg.long_hold_ms     <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_range <= int'(i_key_index) < NUM_KEYS;
            r_key      <= KEY_AW'(i_key_index);
            r_raw      <= i_raw_pressed;
            r_now      <= i_now_ms;
        end
    end

    always_comb begin
        cur_state = '0;
        if (r_in_range) begin
            cur_state = r_keys[key_sel];
        end
    end

    kdc_eval u_eval (
        .i_state (cur_state),
        .i_raw   (r_raw),
        .i_now   (r_now),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_flags (n_flags)
    );

    // key state: write back when the sample moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_keys[k] <= '0;
            end
        end else if (r_in_valid && advance && r_in_range) begin
            r_keys[key_sel] <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= r_in_range ? n_flags : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_single_click = r_out.single_click;
    assign o_double_click = r_out.double_click;
    assign o_long_hold    = r_out.long_hold;
    assign o_stable_level = r_out.stable_level;

    a_long_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.long_hold && (r_out.single_click || r_out.double_click)))
        else $error("long press reported with a click");

    a_long_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.long_hold) |-> r_out.stable_level)
        else $error("long press reported on a released key");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result without a request in the input register");

    a_pending_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_range) |-> !cur_state.click_pending)
        else $error("click left pending after a sample");

endmodule

/* test/key_event_checker.sv */
`timescale 1ns / 1ps
module key_event_checker #(
    parameter int NUM_KEYS = kdc_pkg::NUM_KEYS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kdc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic [kdc_pkg::KEY_IDX_W-1:0] i_key_index,
    input  logic                          i_raw_pressed,
    input  logic [kdc_pkg::TIME_W-1:0]    i_now_ms,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_ready,
    input  logic                          i_single_click,
    input  logic                          i_double_click,
    input  logic                          i_long_hold,
    input  logic                          i_stable_level,
    output int                            o_mismatches,
    output int                            o_outstanding
);
    import kdc_pkg::*;

    localparam int PRINT_CAP = 40;

    t_key_state key_track [NUM_KEYS];
    t_cfg       cfg_live;
    t_flags     expected_flags [$];
    int         mismatch_total = 0;

    task automatic report_mismatch(input string msg);
        if (mismatch_total < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_total++;
    endtask

    task automatic check_field(input string name, input logic got, input logic want);
        if (got !== want)
            report_mismatch($sformatf("%s got %b, expected %b", name, got, want));
    endtask

    function automatic t_flags classify_sample(input logic [KEY_IDX_W-1:0] key,
                                               input logic level,
                                               input logic [TIME_W-1:0] stamp);
        t_key_state        ks;
        t_flags            res;
        logic [TIME_W-1:0] since_change;
        logic [TIME_W-1:0] since_press;
        logic [TIME_W-1:0] press_gap;
        res = '0;
        if (int'(key) >= NUM_KEYS)
            return res;
        ks = key_track[key];

        if (level != ks.raw_prev)
            ks.change_stamp = stamp;
        since_change = stamp - ks.change_stamp;
        if (since_change > TIME_W'(cfg_live.debounce_ms) && level != ks.debounced_level) begin
            ks.debounced_level = level;
            if (level) begin
                ks.press_stamp = stamp;
                if (ks.press_tally != TALLY_MAX)
                    ks.press_tally = ks.press_tally + 1'b1;
                ks.press_consumed = 1'b0;
            end else begin
                ks.release_stamp = stamp;
                if (!ks.press_consumed)
                    ks.click_pending = 1'b1;
            end
        end
        ks.raw_prev = level;

        if (ks.click_pending) begin
            ks.click_pending  = 1'b0;
            ks.press_consumed = 1'b1;
            res.single_click  = 1'b1;
        end

        if (ks.press_tally >= DOUBLE_MIN_PRESSES) begin
            press_gap   = ks.press_stamp - ks.release_stamp;
            since_press = stamp - ks.press_stamp;
            if (press_gap <= TIME_W'(cfg_live.double_window_ms)) begin
                ks.press_tally    = '0;
                ks.press_consumed = 1'b1;
                ks.click_pending  = 1'b0;
                res.double_click  = 1'b1;
            end else if (since_press > TIME_W'(cfg_live.double_window_ms)) begin
                ks.press_tally = '0;
            end
        end

        since_press = stamp - ks.press_stamp;
        if (ks.debounced_level && !ks.press_consumed &&
            since_press >= TIME_W'(cfg_live.long_hold_ms)) begin
            ks.press_consumed = 1'b1;
            ks.click_pending  = 1'b0;
            res.long_hold     = 1'b1;
        end

        res.stable_level = ks.debounced_level;
        key_track[key] = ks;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_flags want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++)
                key_track[k] = '0;
            cfg_live.debounce_ms      = DEBOUNCE_RST;
            cfg_live.double_window_ms = DOUBLE_WINDOW_RST;
            cfg_live.long_hold_ms     = LONG_HOLD_RST;
            expected_flags.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEBOUNCE:      cfg_live.debounce_ms      = i_cfg_data;
                    CFG_DOUBLE_WINDOW: cfg_live.double_window_ms = i_cfg_data;
                    CFG_LONG_HOLD:     cfg_live.long_hold_ms     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                expected_flags.push_back(classify_sample(i_key_index, i_raw_pressed, i_now_ms));
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_flags.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_flags.pop_front();
                    check_field("single_click", i_single_click, want.single_click);
                    check_field("double_click", i_double_click, want.double_click);
                    check_field("long_hold", i_long_hold, want.long_hold);
                    check_field("stable_level", i_stable_level, want.stable_level);
                end
            end
        end
        o_outstanding <= expected_flags.size();
        o_mismatches  <= mismatch_total;
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;
    import kdc_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int PARK_CYCLES = 400;
    localparam int PHASE_ITEMS = 262;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = CFG_DEBOUNCE;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 i_valid       = 1'b0;
    logic                 o_ready;
    logic [KEY_IDX_W-1:0] i_key_index   = '0;
    logic                 i_raw_pressed = 1'b0;
    logic [TIME_W-1:0]    i_now_ms      = '0;
    logic                 o_valid;
    logic                 i_ready       = 1'b0;
    logic                 o_single_click;
    logic                 o_double_click;
    logic                 o_long_hold;
    logic                 o_stable_level;

    int                mismatches;
    int                outstanding;
    int                idle_cycles = 0;
    int                phase_sent  = 0;
    bit                quiet       = 1'b0;
    bit                park_req    = 1'b0;
    int                dbc_ms      = int'(DEBOUNCE_RST);
    int                win_ms      = int'(DOUBLE_WINDOW_RST);
    int                hold_ms     = int'(LONG_HOLD_RST);
    logic [TIME_W-1:0] clock_ms    = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    key_debounce_click_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_key_index    (i_key_index),
        .i_raw_pressed  (i_raw_pressed),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_single_click (o_single_click),
        .o_double_click (o_double_click),
        .o_long_hold    (o_long_hold),
        .o_stable_level (o_stable_level)
    );

    key_event_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_key_index    (i_key_index),
        .i_raw_pressed  (i_raw_pressed),
        .i_now_ms       (i_now_ms),
        .i_rsp_valid    (o_valid),
        .i_rsp_ready    (i_ready),
        .i_single_click (o_single_click),
        .i_double_click (o_double_click),
        .i_long_hold    (o_long_hold),
        .i_stable_level (o_stable_level),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (park_req) begin
                park_req = 1'b0;
                i_ready <= 1'b0;
                repeat (PARK_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    task automatic send_sample(input logic [KEY_IDX_W-1:0] key, input logic level,
                               input logic [TIME_W-1:0] stamp);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_key_index   <= key;
        i_raw_pressed <= level;
        i_now_ms      <= stamp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        phase_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] dbc, input logic [CFG_W-1:0] win,
                                 input logic [CFG_W-1:0] hold);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DEBOUNCE;
        i_cfg_data <= dbc;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DOUBLE_WINDOW;
        i_cfg_data <= win;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LONG_HOLD;
        i_cfg_data <= hold;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dbc_ms  = int'(dbc);
        win_ms  = int'(win);
        hold_ms = int'(hold);
    endtask

    // hold a level long enough for the debouncer to take it
    task automatic hold_level(input logic [KEY_IDX_W-1:0] key, input logic level,
                              input int span);
        int n;
        n = $urandom_range(2, 4);
        send_sample(key, level, clock_ms);
        repeat (n - 1) begin
            clock_ms += TIME_W'(span / (n - 1) + 1);
            send_sample(key, level, clock_ms);
        end
    endtask

    // contact bounce, each edge at most half the debounce time long
    task automatic chatter(input logic [KEY_IDX_W-1:0] key, input logic level);
        repeat ($urandom_range(0, 3)) begin
            clock_ms += TIME_W'($urandom_range(0, dbc_ms / 2));
            send_sample(key, level, clock_ms);
            clock_ms += TIME_W'($urandom_range(0, dbc_ms / 2));
            send_sample(key, !level, clock_ms);
        end
    endtask

    task automatic key_gesture(input logic [KEY_IDX_W-1:0] key);
        repeat ($urandom_range(1, 3)) begin
            chatter(key, 1'b1);
            hold_level(key, 1'b1, dbc_ms + int'($urandom_range(0, hold_ms + hold_ms / 2)));
            chatter(key, 1'b0);
            hold_level(key, 1'b0, dbc_ms + int'($urandom_range(0, win_ms + win_ms / 2)));
        end
    endtask

    task automatic glitch_burst(input logic [KEY_IDX_W-1:0] key);
        repeat ($urandom_range(2, 6)) begin
            clock_ms += TIME_W'($urandom_range(0, dbc_ms + 2));
            send_sample(key, 1'($urandom_range(0, 1)), clock_ms);
        end
    endtask

    task automatic run_phase(input int items, input bit park_mid, input bit pause_mid);
        int pick;
        phase_sent = 0;
        clock_ms   = $urandom();
        while (phase_sent < items) begin
            pick = $urandom_range(0, 19);
            if (pick < 15)
                key_gesture(KEY_IDX_W'($urandom_range(0, 7)));
            else if (pick < 18)
                glitch_burst(KEY_IDX_W'($urandom_range(0, 7)));
            else
                send_sample(KEY_IDX_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                            $urandom());
            if (phase_sent >= items / 2) begin
                if (park_mid) begin
                    park_req = 1'b1;
                    park_mid = 1'b0;
                end
                if (pause_mid) begin
                    drain();
                    pause_mid = 1'b0;
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // long press, then release of a consumed press
        send_sample(3'd7, 1'b1, 32'd0);
        send_sample(3'd7, 1'b1, 32'd51);
        send_sample(3'd7, 1'b1, 32'd1051);
        send_sample(3'd7, 1'b0, 32'd1100);
        send_sample(3'd7, 1'b0, 32'd1151);
        // single then double click across the time stamp wrap
        send_sample(3'd0, 1'b1, 32'hFFFF_FF00);
        send_sample(3'd0, 1'b1, 32'hFFFF_FF40);
        send_sample(3'd0, 1'b0, 32'hFFFF_FF50);
        send_sample(3'd0, 1'b0, 32'hFFFF_FFFF);
        send_sample(3'd0, 1'b1, 32'h0000_0010);
        send_sample(3'd0, 1'b1, 32'h0000_0050);
        // debounce and long press exactly at their limits
        send_sample(3'd2, 1'b1, 32'd1000);
        send_sample(3'd2, 1'b1, 32'd1050);
        send_sample(3'd2, 1'b1, 32'd1051);
        send_sample(3'd2, 1'b1, 32'd2050);
        send_sample(3'd2, 1'b1, 32'd2051);
        // double click gap exactly at the window
        send_sample(3'd4, 1'b1, 32'd0);
        send_sample(3'd4, 1'b1, 32'd51);
        send_sample(3'd4, 1'b0, 32'd100);
        send_sample(3'd4, 1'b0, 32'd151);
        send_sample(3'd4, 1'b1, 32'd500);
        send_sample(3'd4, 1'b1, 32'd551);
        // bounce that never settles
        send_sample(3'd5, 1'b1, 32'd10);
        send_sample(3'd5, 1'b0, 32'd12);
        send_sample(3'd5, 1'b1, 32'd14);
        drain();

        load_settings(16'd0, 16'd0, 16'd0);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);
        drain();
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);
        drain();
        for (int p = 0; p < 4; p++) begin
            load_settings(CFG_W'($urandom_range(0, 100)), CFG_W'($urandom_range(0, 600)),
                          CFG_W'($urandom_range(0, 3000)));
            run_phase(PHASE_ITEMS, p == 0, p == 1);
            drain();
        end
        quiet = 1'b1;
        load_settings(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                      CFG_W'($urandom_range(0, 65535)));
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);
        drain();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
